### hw/rtl/tte_pkg.sv
package tte_pkg;

  localparam int TIME_W         = 32;
  localparam int HIST_DEPTH_DEF = 8;
  localparam int TEMPO_W        = 16;
  localparam int TAPS_W         = 4;
  localparam int IVOUT_W        = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  // hundredths of BPM times microseconds per minute
  localparam logic [63:0] CENTI_BPM_US = 64'd6000000000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_GAP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_IV    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_IV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CEIL      = 3'd4;

  localparam logic [TIME_W-1:0]  RESET_GAP_RST = 32'd2000000;
  localparam logic [TIME_W-1:0]  MIN_IV_RST    = 32'd100000;
  localparam logic [TIME_W-1:0]  MAX_IV_RST    = 32'd2000000;
  localparam logic [TEMPO_W-1:0] FLOOR_RST     = 16'd2000;
  localparam logic [TEMPO_W-1:0] CEIL_RST      = 16'd30000;
  localparam logic [TEMPO_W-1:0] TEMPO_RST     = 16'd12000;

  typedef struct packed {
    logic load;
    logic scan;
    logic div_start;
    logic tempo_load;
    logic out_load;
  } tte_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic have_iv;
    logic div_done;
  } tte_sts_t;

endpackage

### hw/rtl/tte_div.sv
module tte_div #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 35
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0]  den_r;
  logic [DEN_W-1:0]  rem_r;
  logic [NUM_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              fits;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = ~diff[DEN_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

### hw/rtl/tte_dpath.sv
module tte_dpath #(
  parameter int HISTORY_DEPTH = tte_pkg::HIST_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tte_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [tte_pkg::TIME_W-1:0]     in_tap_time_us,
  input  tte_pkg::tte_cmd_t              cmd,
  output tte_pkg::tte_sts_t              sts,
  output logic [tte_pkg::TEMPO_W-1:0]    out_tempo_centi_bpm,
  output logic                           out_tempo_updated,
  output logic [tte_pkg::TAPS_W-1:0]     out_taps_held,
  output logic [tte_pkg::IVOUT_W-1:0]    out_intervals_used
);
  import tte_pkg::*;

  localparam int D     = HISTORY_DEPTH;
  localparam int PTR_W = $clog2(D);
  localparam int CNT_W = $clog2(D + 1);
  localparam int IV_W  = $clog2(D);
  localparam int SUM_W = TIME_W + IV_W;
  localparam logic [63:0] NUM_MAX = CENTI_BPM_US * 64'(D - 1);
  localparam int NUM_W = $clog2(NUM_MAX + 64'd1);
  localparam logic [NUM_W-1:0] K_NUM    = CENTI_BPM_US[NUM_W-1:0];
  localparam logic [CNT_W-1:0] D_CNT    = CNT_W'(D);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(D - 1);
  localparam logic [CNT_W:0]   D_EXT    = (CNT_W + 1)'(D);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  // configuration
  logic [TIME_W-1:0]  reset_gap_r, min_iv_r, max_iv_r;
  logic [TEMPO_W-1:0] floor_r, ceil_r;

  // tap state
  logic [TIME_W-1:0]  hist_mem [D];
  logic [TIME_W-1:0]  rd_data_r;
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r, scan_idx_r;
  logic [TIME_W-1:0]  prev_tap_r, prev_hist_r;
  logic               seen_r;
  logic [SUM_W-1:0]   sum_r;
  logic [IV_W-1:0]    iv_r;
  logic [TEMPO_W-1:0] tempo_r;
  logic               upd_r;

  // result register
  logic [TEMPO_W-1:0] out_tempo_r;
  logic               out_upd_r;
  logic [TAPS_W-1:0]  out_taps_r;
  logic [IVOUT_W-1:0] out_iv_r;

  logic [TIME_W-1:0]  gap_in, gap;
  logic               clear;
  logic [CNT_W-1:0]   kept, cnt_nxt;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [CNT_W:0]     oldest_sum, oldest_ext;
  logic               gap_ok;
  logic [NUM_W-1:0]   div_num, div_quot, floor_ext, ceil_ext;
  logic               div_done;
  logic [TEMPO_W-1:0] tempo_nxt;
  logic [CNT_W+TAPS_W-1:0] taps_ext;
  logic [IV_W+IVOUT_W-1:0] iv_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reset_gap_r <= RESET_GAP_RST;
      min_iv_r    <= MIN_IV_RST;
      max_iv_r    <= MAX_IV_RST;
      floor_r     <= FLOOR_RST;
      ceil_r      <= CEIL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_GAP: reset_gap_r <= cfg_data;
        REG_MIN_IV:    min_iv_r    <= cfg_data;
        REG_MAX_IV:    max_iv_r    <= cfg_data;
        REG_FLOOR:     floor_r     <= cfg_data[TEMPO_W-1:0];
        REG_CEIL:      ceil_r      <= cfg_data[TEMPO_W-1:0];
        default: ;
      endcase
    end
  end

  // a long pause or the first tap after reset starts a fresh history
  assign gap_in     = in_tap_time_us - prev_tap_r;
  assign clear      = !seen_r || (gap_in > reset_gap_r);
  assign kept       = clear ? '0 : ((cnt_r == D_CNT) ? D_CNT - 1'b1 : cnt_r);
  assign cnt_nxt    = kept + 1'b1;
  assign wr_ptr_nxt = ptr_inc(wr_ptr_r);
  assign oldest_sum = (CNT_W + 1)'(wr_ptr_nxt) + D_EXT - (CNT_W + 1)'(cnt_nxt);
  assign oldest_ext = (oldest_sum >= D_EXT) ? oldest_sum - D_EXT : oldest_sum;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hist_mem[wr_ptr_r] <= in_tap_time_us;
    end
    rd_data_r <= hist_mem[rd_ptr_r];
  end

  assign gap    = rd_data_r - prev_hist_r;
  assign gap_ok = (gap > min_iv_r) && (gap < max_iv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      cnt_r      <= '0;
      prev_tap_r <= '0;
      seen_r     <= 1'b0;
      tempo_r    <= TEMPO_RST;
    end else begin
      if (cmd.load) begin
        wr_ptr_r   <= wr_ptr_nxt;
        cnt_r      <= cnt_nxt;
        prev_tap_r <= in_tap_time_us;
        seen_r     <= 1'b1;
      end
      if (cmd.tempo_load) begin
        tempo_r <= tempo_nxt;
      end
    end
  end

  // scan step n reads entry n and checks entry n-1 against entry n-2
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_ptr_r   <= oldest_ext[PTR_W-1:0];
      scan_idx_r <= '0;
      sum_r      <= '0;
      iv_r       <= '0;
      upd_r      <= 1'b0;
    end else begin
      if (cmd.scan) begin
        rd_ptr_r   <= ptr_inc(rd_ptr_r);
        scan_idx_r <= scan_idx_r + 1'b1;
        if (scan_idx_r != '0) begin
          prev_hist_r <= rd_data_r;
          if ((scan_idx_r != CNT_W'(1)) && gap_ok) begin
            sum_r <= sum_r + SUM_W'(gap);
            iv_r  <= iv_r + 1'b1;
          end
        end
      end
      if (cmd.tempo_load) begin
        upd_r <= 1'b1;
      end
    end
  end

  assign div_num = K_NUM * NUM_W'(iv_r);

  tte_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (sum_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // when the limits cross, a quotient below the floor gives the floor and any other gives the ceiling
  assign floor_ext = NUM_W'(floor_r);
  assign ceil_ext  = NUM_W'(ceil_r);
  assign tempo_nxt = (div_quot < floor_ext) ? floor_r :
                     (div_quot > ceil_ext)  ? ceil_r  : div_quot[TEMPO_W-1:0];

  assign taps_ext = (CNT_W + TAPS_W)'(cnt_r);
  assign iv_ext   = (IV_W + IVOUT_W)'(iv_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tempo_r <= tempo_r;
      out_upd_r   <= upd_r;
      out_taps_r  <= taps_ext[TAPS_W-1:0];
      out_iv_r    <= upd_r ? iv_ext[IVOUT_W-1:0] : '0;
    end
  end

  assign sts.scan_last = (scan_idx_r == cnt_r);
  assign sts.have_iv   = (iv_r != '0) && (sum_r != '0);
  assign sts.div_done  = div_done;

  assign out_tempo_centi_bpm = out_tempo_r;
  assign out_tempo_updated   = out_upd_r;
  assign out_taps_held       = out_taps_r;
  assign out_intervals_used  = out_iv_r;

endmodule

### hw/rtl/tte_ctrl.sv
module tte_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tte_pkg::tte_sts_t sts,
  output tte_pkg::tte_cmd_t cmd
);
  import tte_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_CHECK = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } tte_state_t;

  tte_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // no usable interval: hold the tempo
        if (sts.have_iv) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.tempo_load = 1'b1;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### hw/rtl/tap_tempo_estimator.sv
// Channel  Dir  Handshake            Payload
// cfg      in   cfg_we               cfg_index, cfg_data
// in       in   in_valid, in_ready   in_tap_time_us
// out      out  out_valid, out_ready tempo_centi_bpm, tempo_updated, taps_held, intervals_used
//
// One request at a time. A request that updates the tempo runs the history scan and then
// the 36-step restoring divider (at the default depth of 8), one quotient bit a cycle, before
// the next request is taken; a request with no usable interval skips the divider.
// Reset is synchronous, active low; the history needs no clearing pass.
// A result waits in the output register while the next request is taken in;
// only a second result stalls until the first one leaves.
module tap_tempo_estimator #(
  parameter int HISTORY_DEPTH = tte_pkg::HIST_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tte_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tte_pkg::TIME_W-1:0]     in_tap_time_us,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tte_pkg::TEMPO_W-1:0]    out_tempo_centi_bpm,
  output logic                           out_tempo_updated,
  output logic [tte_pkg::TAPS_W-1:0]     out_taps_held,
  output logic [tte_pkg::IVOUT_W-1:0]    out_intervals_used
);
  import tte_pkg::*;

  tte_cmd_t cmd;
  tte_sts_t sts;

  tte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tte_dpath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_tap_time_us      (in_tap_time_us),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_tempo_centi_bpm (out_tempo_centi_bpm),
    .out_tempo_updated   (out_tempo_updated),
    .out_taps_held       (out_taps_held),
    .out_intervals_used  (out_intervals_used)
  );

endmodule

### hw/rtl/tte_chk.sv
module tte_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tte_pkg::TEMPO_W-1:0] out_tempo_centi_bpm,
  input logic                        out_tempo_updated,
  input logic [tte_pkg::TAPS_W-1:0]  out_taps_held,
  input logic [tte_pkg::IVOUT_W-1:0] out_intervals_used
);

  // a taken request drops in_ready in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after a request was taken");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_tempo_centi_bpm, out_tempo_updated, out_taps_held, out_intervals_used}))
    else $error("result changed while stalled");

  // a held tempo reports no intervals
  a_held_no_iv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tempo_updated |-> out_intervals_used == '0)
    else $error("intervals reported on a held tempo");

  // a result only appears from a busy block
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

endmodule

bind tap_tempo_estimator tte_chk u_tte_chk (.*);

### test/tap_tempo_estimator_tb.sv
module tap_tempo_estimator_tb;
  import tte_pkg::*;

  localparam int          TAP_DEPTH  = 8;
  localparam int          QUIET_MAX  = 3000;
  localparam int          LONG_HOLD  = 400;
  localparam logic [63:0] CENTI_US   = 64'd6000000000;
  localparam int          PHASES     = 10;
  localparam int          PHASE_TAPS = 70;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [TEMPO_W-1:0] tempo;
    logic               updated;
    logic [TAPS_W-1:0]  taps;
    logic [IVOUT_W-1:0] used;
  } tempo_report_t;

  typedef enum bit {ROW_TAP, ROW_CFG} row_kind_t;
  typedef enum bit {WANT_PREDICTED, WANT_FIXED} want_src_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [31:0]          value;
    want_src_t            src;
    tempo_report_t        want;
  } script_row_t;

  localparam tempo_report_t NO_WANT = '0;

  localparam script_row_t SCRIPT [38] = '{
    '{ROW_TAP, REG_RESET_GAP, 32'd0,          WANT_FIXED, '{16'd12000, 1'b0, 4'd1, 3'd0}},
    '{ROW_TAP, REG_RESET_GAP, 32'd500000,     WANT_FIXED, '{16'd12000, 1'b1, 4'd2, 3'd1}},
    '{ROW_TAP, REG_RESET_GAP, 32'd1000000,    WANT_FIXED, '{16'd12000, 1'b1, 4'd3, 3'd2}},
    '{ROW_TAP, REG_RESET_GAP, 32'd5000000,    WANT_FIXED, '{16'd12000, 1'b0, 4'd1, 3'd0}},
    '{ROW_TAP, REG_RESET_GAP, 32'd5100000,    WANT_FIXED, '{16'd12000, 1'b0, 4'd2, 3'd0}},
    '{ROW_TAP, REG_RESET_GAP, 32'd5200001,    WANT_FIXED, '{16'd30000, 1'b1, 4'd3, 3'd1}},
    '{ROW_TAP, REG_RESET_GAP, 32'd7200000,    WANT_PREDICTED, NO_WANT},
    '{ROW_TAP, REG_RESET_GAP, 32'd9200000,    WANT_PREDICTED, NO_WANT},
    '{ROW_TAP, REG_RESET_GAP, 32'hFFFF_FFFF,  WANT_PREDICTED, NO_WANT},
    '{ROW_TAP, REG_RESET_GAP, 32'h0007_A11F,  WANT_FIXED, '{16'd12000, 1'b1, 4'd2, 3'd1}},
    '{ROW_TAP, REG_RESET_GAP, 32'd1099999,    WANT_PREDICTED, NO_WANT},
    '{ROW_TAP, REG_RESET_GAP, 32'd1699999,    WANT_PREDICTED, NO_WANT},
    '{ROW_TAP, REG_RESET_GAP, 32'd2299999,    WANT_PREDICTED, NO_WANT},
    '{ROW_TAP, REG_RESET_GAP, 32'd2899999,    WANT_PREDICTED, NO_WANT},
    '{ROW_TAP, REG_RESET_GAP, 32'd3499999,    WANT_PREDICTED, NO_WANT},
    '{ROW_TAP, REG_RESET_GAP, 32'd4099999,    WANT_PREDICTED, NO_WANT},
    '{ROW_TAP, REG_RESET_GAP, 32'd4699999,    WANT_FIXED, '{16'd10000, 1'b1, 4'd8, 3'd7}},
    // crossed limits, widest window, near-zero reset gap
    '{ROW_CFG, REG_RESET_GAP, 32'd1,          WANT_PREDICTED, NO_WANT},
    '{ROW_CFG, REG_MIN_IV,    32'd0,          WANT_PREDICTED, NO_WANT},
    '{ROW_CFG, REG_MAX_IV,    32'hFFFF_FFFF,  WANT_PREDICTED, NO_WANT},
    '{ROW_CFG, REG_FLOOR,     32'd65535,      WANT_PREDICTED, NO_WANT},
    '{ROW_CFG, REG_CEIL,      32'd1,          WANT_PREDICTED, NO_WANT},
    '{ROW_TAP, REG_RESET_GAP, 32'h8000_0000,  WANT_FIXED, '{16'd10000, 1'b0, 4'd1, 3'd0}},
    '{ROW_TAP, REG_RESET_GAP, 32'h8000_0001,  WANT_FIXED, '{16'd1,     1'b1, 4'd2, 3'd1}},
    '{ROW_TAP, REG_RESET_GAP, 32'h8000_0001,  WANT_FIXED, '{16'd1,     1'b1, 4'd3, 3'd1}},
    '{ROW_CFG, REG_RESET_GAP, 32'hFFFF_FFFF,  WANT_PREDICTED, NO_WANT},
    '{ROW_CFG, REG_FLOOR,     32'd1,          WANT_PREDICTED, NO_WANT},
    '{ROW_CFG, REG_CEIL,      32'd65535,      WANT_PREDICTED, NO_WANT},
    '{ROW_TAP, REG_RESET_GAP, 32'h8000_0004,  WANT_FIXED, '{16'd65535, 1'b1, 4'd4, 3'd2}},
    '{ROW_TAP, REG_RESET_GAP, 32'h7FFF_FFFF,  WANT_FIXED, '{16'd4,     1'b1, 4'd5, 3'd3}},
    // empty window, and writes to indexes past the last register
    '{ROW_CFG, REG_MIN_IV,    32'd5,          WANT_PREDICTED, NO_WANT},
    '{ROW_CFG, REG_MAX_IV,    32'd5,          WANT_PREDICTED, NO_WANT},
    '{ROW_CFG, REG_UNUSED_LO, 32'hA5A5_A5A5,  WANT_PREDICTED, NO_WANT},
    '{ROW_CFG, REG_UNUSED_HI, 32'h5A5A_5A5A,  WANT_PREDICTED, NO_WANT},
    '{ROW_TAP, REG_RESET_GAP, 32'h8000_0009,  WANT_FIXED, '{16'd4,     1'b0, 4'd6, 3'd0}},
    '{ROW_CFG, REG_RESET_GAP, 32'd0,          WANT_PREDICTED, NO_WANT},
    '{ROW_TAP, REG_RESET_GAP, 32'h8000_0009,  WANT_FIXED, '{16'd4,     1'b0, 4'd7, 3'd0}},
    '{ROW_TAP, REG_RESET_GAP, 32'h8000_000A,  WANT_FIXED, '{16'd4,     1'b0, 4'd1, 3'd0}}
  };

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [TIME_W-1:0]    in_tap_time_us = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic [TEMPO_W-1:0]   out_tempo_centi_bpm;
  logic                 out_tempo_updated;
  logic [TAPS_W-1:0]    out_taps_held;
  logic [IVOUT_W-1:0]   out_intervals_used;

  // own copy of the block's registers and tap history
  logic [31:0] gap_limit, iv_min, iv_max;
  logic [15:0] tempo_lo, tempo_hi, tempo_held;
  logic [31:0] tap_ring [TAP_DEPTH];
  int unsigned taps_kept;
  logic [31:0] last_tap;
  bit          tapped;

  tempo_report_t pending_reports [$];
  int unsigned   mismatches  = 0;
  int unsigned   quiet_cycles = 0;
  bit            long_hold_req = 1'b0;
  bit            reader_calm   = 1'b0;

  tap_tempo_estimator u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_tap_time_us      (in_tap_time_us),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tempo_centi_bpm (out_tempo_centi_bpm),
    .out_tempo_updated   (out_tempo_updated),
    .out_taps_held       (out_taps_held),
    .out_intervals_used  (out_intervals_used)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void absorb_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    case (idx)
      REG_RESET_GAP: gap_limit = val;
      REG_MIN_IV:    iv_min    = val;
      REG_MAX_IV:    iv_max    = val;
      REG_FLOOR:     tempo_lo  = val[15:0];
      REG_CEIL:      tempo_hi  = val[15:0];
      default: ;
    endcase
  endfunction

  function automatic tempo_report_t track_tap(logic [31:0] now);
    logic [31:0]   gap;
    logic [63:0]   span_sum;
    logic [63:0]   quot;
    int unsigned   n_iv;
    int unsigned   i;
    tempo_report_t rep;
    gap = now - last_tap;
    if (!tapped || gap > gap_limit) taps_kept = 0;
    // drop the oldest tap once the history is full
    if (taps_kept >= TAP_DEPTH) begin
      for (i = 1; i < TAP_DEPTH; i++) tap_ring[i-1] = tap_ring[i];
      taps_kept = TAP_DEPTH - 1;
    end
    tap_ring[taps_kept] = now;
    taps_kept++;
    last_tap = now;
    tapped   = 1'b1;
    span_sum = '0;
    n_iv     = 0;
    for (i = 1; i < taps_kept; i++) begin
      gap = tap_ring[i] - tap_ring[i-1];
      if (gap > iv_min && gap < iv_max) begin
        span_sum += 64'(gap);
        n_iv++;
      end
    end
    rep.updated = 1'b0;
    rep.used    = '0;
    if (n_iv > 0) begin
      quot = (CENTI_US * 64'(n_iv)) / span_sum;
      if (quot < 64'(tempo_lo)) quot = 64'(tempo_lo);
      else if (quot > 64'(tempo_hi)) quot = 64'(tempo_hi);
      tempo_held  = quot[15:0];
      rep.updated = 1'b1;
      rep.used    = IVOUT_W'(n_iv);
    end
    rep.tempo = tempo_held;
    rep.taps  = TAPS_W'(taps_kept);
    return rep;
  endfunction

  function automatic int unsigned pick_pause(bit calm);
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(4, 1);
    return $urandom_range(90, 20);
  endfunction

  // mostly taps that land inside the counting window, with resets and noise mixed in
  function automatic logic [31:0] next_stamp(logic [31:0] from);
    logic [31:0] lo;
    logic [31:0] cap;
    int unsigned r;
    r   = $urandom_range(99);
    lo  = iv_min + 32'd1;
    cap = (iv_max - 32'd1 < gap_limit) ? iv_max - 32'd1 : gap_limit;
    if (r < 75 && iv_min != '1 && iv_max != '0 && lo <= cap)
      return from + $urandom_range(cap, lo);
    if (r < 85) return from + $urandom_range(iv_min, 0);
    if (r < 93) return from + gap_limit + $urandom_range(3000000, 1);
    return $urandom;
  endfunction

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic offer_tap(logic [31:0] stamp, want_src_t src, tempo_report_t fixed_want,
                           int unsigned pause_after);
    tempo_report_t guess;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_tap_time_us <= stamp;
    do @(posedge clk); while (!in_ready);
    guess = track_tap(stamp);
    pending_reports.insert(pending_reports.size(), (src == WANT_FIXED) ? fixed_want : guess);
    if (pause_after > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (pause_after - 1) @(negedge clk);
    end
  endtask

  // hold requests back until every result is home
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    absorb_reg(idx, val);
  endtask

  task automatic cfg_close();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : tempo_reader
    int unsigned stall;
    int unsigned hold;
    stall = 0;
    hold  = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold          = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (reader_calm || $urandom_range(99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        stall = pick_pause(1'b0);
        out_ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    tempo_report_t got;
    tempo_report_t want;
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (out_valid && out_ready) begin
      got = '{out_tempo_centi_bpm, out_tempo_updated, out_taps_held, out_intervals_used};
      if (pending_reports.size() == 0) begin
        flag_mismatch("result with nothing pending, tempo", got.tempo, 0);
      end else begin
        want = pending_reports.pop_front();
        if (got.tempo !== want.tempo)
          flag_mismatch("tempo_centi_bpm", got.tempo, want.tempo);
        if (got.updated !== want.updated)
          flag_mismatch("tempo_updated", got.updated, want.updated);
        if (got.taps !== want.taps)
          flag_mismatch("taps_held", got.taps, want.taps);
        if (got.used !== want.used)
          flag_mismatch("intervals_used", got.used, want.used);
      end
    end
    if (quiet_cycles >= QUIET_MAX) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_MAX);
      $display("** tap_tempo_estimator: FAILED **");
      $finish;
    end
  end

  initial begin : tap_source
    int unsigned phase;
    int unsigned k;
    logic [31:0] stamp;
    logic [31:0] v_gap, v_min, v_max, v_floor, v_ceil;
    bit          writing;
    bit          source_calm;

    gap_limit  = 32'd2000000;
    iv_min     = 32'd100000;
    iv_max     = 32'd2000000;
    tempo_lo   = 16'd2000;
    tempo_hi   = 16'd30000;
    tempo_held = 16'd12000;
    taps_kept  = 0;
    last_tap   = '0;
    tapped     = 1'b0;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    writing = 1'b0;
    foreach (SCRIPT[r]) begin
      if (SCRIPT[r].kind == ROW_CFG) begin
        if (!writing) settle();
        writing = 1'b1;
        cfg_write(SCRIPT[r].reg_idx, SCRIPT[r].value);
      end else begin
        if (writing) cfg_close();
        writing = 1'b0;
        offer_tap(SCRIPT[r].value, SCRIPT[r].src, SCRIPT[r].want, pick_pause(1'b0));
      end
    end

    stamp = $urandom;
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase % 6)
        0: begin
          v_gap = 32'd2000000; v_min = 32'd100000; v_max = 32'd2000000;
          v_floor = 32'd2000; v_ceil = 32'd30000;
        end
        1: begin
          v_gap   = $urandom_range(3000000, 1500000);
          v_min   = $urandom_range(200000, 50000);
          v_max   = $urandom_range(2500000, 1000000);
          v_floor = $urandom_range(5000, 1000);
          v_ceil  = $urandom_range(40000, 15000);
        end
        2: begin
          if (phase < 6) begin
            v_gap = '1; v_min = '0; v_max = '1; v_floor = 32'd1; v_ceil = 32'd65535;
          end else begin
            v_gap = '0; v_min = '1; v_max = 32'd1; v_floor = 32'd65535; v_ceil = 32'd1;
          end
        end
        3: begin
          v_gap   = 32'd2000000; v_min = 32'd100000; v_max = 32'd2000000;
          v_floor = $urandom_range(65535, 12001);
          v_ceil  = $urandom_range(12000, 1);
        end
        4: begin
          v_gap   = $urandom_range(4000000, 2000000);
          v_min   = $urandom_range(3000000, 100000);
          v_max   = $urandom_range(v_min, 1);
          v_floor = $urandom_range(5000, 1);
          v_ceil  = $urandom_range(65535, 5000);
        end
        default: begin
          v_gap   = $urandom;
          v_min   = $urandom;
          v_max   = $urandom;
          v_floor = $urandom_range(65535, 1);
          v_ceil  = $urandom_range(65535, 1);
        end
      endcase
      cfg_write(REG_RESET_GAP, v_gap);
      cfg_write(REG_MIN_IV, v_min);
      cfg_write(REG_MAX_IV, v_max);
      cfg_write(REG_FLOOR, v_floor);
      cfg_write(REG_CEIL, v_ceil);
      cfg_close();

      source_calm = (phase == 5);
      reader_calm = (phase == 5);
      // hold the reader off long enough for the request path to back up
      if (phase == 3) long_hold_req = 1'b1;
      for (k = 0; k < PHASE_TAPS; k++) begin
        stamp = next_stamp(stamp);
        offer_tap(stamp, WANT_PREDICTED, NO_WANT, pick_pause(source_calm));
      end
    end

    reader_calm = 1'b0;
    settle();
    repeat (60) @(posedge clk);
    if (mismatches == 0)
      $display("** tap_tempo_estimator: PASSED **");
    else
      $display("** tap_tempo_estimator: FAILED **");
    $finish;
  end

endmodule

### files.f
hw/rtl/tte_pkg.sv
hw/rtl/tte_div.sv
hw/rtl/tte_dpath.sv
hw/rtl/tte_ctrl.sv
hw/rtl/tap_tempo_estimator.sv
hw/rtl/tte_chk.sv
test/tap_tempo_estimator_tb.sv
